/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold on every enabled clock edge
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif

`endif

/* src/rcv_pkg.sv */
// ---------------------------------------------------------------------------
// rcv_pkg
// Shared types and widths for the rank compression block.
// ---------------------------------------------------------------------------
package rcv_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int RANK_W  = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [RANK_W-1:0] rank;
    logic              final_res;
  } out_item_t;

  // broadcast control to every cell in the chain
  typedef struct packed {
    logic start;   // copy own value into the travelling slot, rank to one
    logic rotate;  // travelling slot moves one cell round the ring
    logic drain;   // ranks shift one cell towards the output end
  } cell_ctrl_t;

endpackage

/* src/rank_compress_values.sv */
// ---------------------------------------------------------------------------
// rank_compress_values
// Coordinate compression: one rank per stored value, in arrival order.
// ---------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------
//  item     | item_valid / item_ready     | in_item_t  {value, last}
//  result   | result_valid / result_ready | out_item_t {position, rank, final_res}
//
//  Load: one item per cycle; item n is written into cell n of the chain.
//  After the closing item: a start step, then rotation steps
//  while every value travels once round the ring of cells; this ring walk
//  sets the ranking time, independent of the set size.
//  Results: one per cycle while result_ready is high, ranks shifting out of cell 0; no items are taken
//  from the closing item until the final result has gone.
//  Reset clears control only; the value store needs no clearing pass.
//  A stalled result simply holds; the chain waits with it.
// ---------------------------------------------------------------------------
module rank_compress_values #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  rcv_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output rcv_pkg::out_item_t result
);
  import rcv_pkg::*;

  `include "assert_macros.svh"

  localparam int CW  = $clog2(MAX_ITEMS + 1);             // fill count width
  localparam int RTW = (MAX_ITEMS > 2) ? $clog2(MAX_ITEMS - 1) : 1;

  typedef enum logic [1:0] {S_LOAD, S_START, S_RANK, S_EMIT} state_t;

  state_t          state;
  logic [CW-1:0]   count;     // values held
  logic [CW-1:0]   pos;       // position of the result on offer
  logic [RTW-1:0]  rot;       // rotation steps done

  logic            item_acc;
  logic            result_acc;
  logic            store;
  cell_ctrl_t      ctrl;

  logic signed [VALUE_W-1:0] circ   [MAX_ITEMS];
  logic                      circ_v [MAX_ITEMS];
  logic [RANK_W-1:0]         rank   [MAX_ITEMS];

  assign item_ready   = (state == S_LOAD);
  assign result_valid = (state == S_EMIT);
  assign item_acc     = item_valid && item_ready;
  assign result_acc   = result_valid && result_ready;
  assign store        = item_acc && (count < CW'(MAX_ITEMS));  // beyond capacity: dropped

  always_comb begin
    ctrl        = '0;
    ctrl.start  = (state == S_START);
    ctrl.rotate = (state == S_RANK);
    ctrl.drain  = result_acc;
  end

  // chain of cells; the travelling slots form a ring, ranks drain to cell 0
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    rcv_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .load           (store && (count == CW'(i))),
      .active         (count > CW'(i)),
      .value          (item.value),
      .circ_in        (circ[(i + MAX_ITEMS - 1) % MAX_ITEMS]),
      .circ_in_valid  (circ_v[(i + MAX_ITEMS - 1) % MAX_ITEMS]),
      .circ_out       (circ[i]),
      .circ_out_valid (circ_v[i]),
      .rank_in        ((i == MAX_ITEMS - 1) ? '0 : rank[(i + 1) % MAX_ITEMS]),
      .rank_out       (rank[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      pos   <= '0;
      rot   <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (store) begin
            count <= count + CW'(1);
          end
          if (item_acc && item.last) begin
            state <= S_START;
          end
        end
        S_START: begin
          rot <= '0;
          pos <= CW'(1);
          // a single-cell chain has nothing to rotate
          state <= (MAX_ITEMS > 1) ? S_RANK : S_EMIT;
        end
        S_RANK: begin
          rot <= rot + RTW'(1);
          if (rot == RTW'(MAX_ITEMS - 2)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (result_acc) begin
            pos <= pos + CW'(1);
            if (pos == count) begin
              count <= '0;      // store emptied once the set is out
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign result.position  = POS_W'(pos);
  assign result.rank      = rank[0];
  assign result.final_res = (pos == count);

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  `ASSERT_ALWAYS(a_no_overlap, clk, rst, !(item_ready && result_valid), "load and emit overlap")
  `ASSERT_ALWAYS(a_pos_range, clk, rst, !result_valid || ((pos != '0) && (pos <= count)), "result position out of range")
  `ASSERT_NEXT(a_empty_after_final, clk, rst, result_acc && result.final_res, item_ready && (count == '0), "store not emptied after final result")
  `ASSERT_NEXT(a_count_cap, clk, rst, item_acc, count <= CW'(MAX_ITEMS), "fill count beyond capacity")

endmodule

/* src/rcv_cell.sv */
// ---------------------------------------------------------------------------
// rcv_cell
// One chain cell: holds a value, counts smaller values passing through it.
// ---------------------------------------------------------------------------
module rcv_cell (
  input  logic                               clk,
  input  logic                               rst,
  input  rcv_pkg::cell_ctrl_t                ctrl,
  input  logic                               load,
  input  logic                               active,
  input  logic signed [rcv_pkg::VALUE_W-1:0] value,
  input  logic signed [rcv_pkg::VALUE_W-1:0] circ_in,
  input  logic                               circ_in_valid,
  output logic signed [rcv_pkg::VALUE_W-1:0] circ_out,
  output logic                               circ_out_valid,
  input  logic [rcv_pkg::RANK_W-1:0]         rank_in,
  output logic [rcv_pkg::RANK_W-1:0]         rank_out
);
  import rcv_pkg::*;

  logic signed [VALUE_W-1:0] own;
  logic signed [VALUE_W-1:0] circ;
  logic                      circ_valid;
  logic [RANK_W-1:0]         rank;

  always_ff @(posedge clk) begin
    if (load) begin
      own <= value;
    end
    if (ctrl.start) begin
      circ <= own;
      rank <= RANK_W'(1);
    end else if (ctrl.rotate) begin
      circ <= circ_in;
      if (circ_in_valid && (circ_in < own)) begin
        rank <= rank + RANK_W'(1);
      end
    end else if (ctrl.drain) begin
      rank <= rank_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      circ_valid <= 1'b0;
    end else if (ctrl.start) begin
      circ_valid <= active;
    end else if (ctrl.rotate) begin
      circ_valid <= circ_in_valid;
    end
  end

  assign circ_out       = circ;
  assign circ_out_valid = circ_valid;
  assign rank_out       = rank;

endmodule
